[rtl/core/lrhf_pkg.sv]
package lrhf_pkg;

  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned NIBBLE_BITS    = 4;
  localparam int unsigned WORD_NIBBLES   = WORD_BITS / NIBBLE_BITS;
  localparam int unsigned WORD_DIGITS_DEF = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       nonzero;
  } lane_res_t;

  typedef enum logic [4:0] {
    PH_ID  = 5'b00001,
    PH_SP  = 5'b00010,
    PH_PAR = 5'b00100,
    PH_CR  = 5'b01000,
    PH_LF  = 5'b10000
  } phase_e;

endpackage

[rtl/core/lrhf_in_if.sv]
interface lrhf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_id;
  logic [31:0] event_param;

  modport source (output valid, output event_id, output event_param, input ready);
  modport sink (input valid, input event_id, input event_param, output ready);
endinterface

[rtl/core/lrhf_out_if.sv]
interface lrhf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

[rtl/core/lrhf_lane.sv]
module lrhf_lane (
  input  logic [3:0]          nib_i,
  output lrhf_pkg::lane_res_t res_o
);
  import lrhf_pkg::*;

  assign res_o.char_byte = HEX_CHARS[nib_i];
  assign res_o.nonzero   = (nib_i != 4'h0);
endmodule

[rtl/core/lrhf_merge.sv]
module lrhf_merge #(
  parameter int unsigned WORD_DIGITS = lrhf_pkg::WORD_DIGITS_DEF,
  parameter int unsigned DIG_W       = (WORD_DIGITS > 1) ? $clog2(WORD_DIGITS) : 1
) (
  input  lrhf_pkg::lane_res_t lanes_i [WORD_DIGITS],
  output logic [DIG_W-1:0]    top_o
);
  import lrhf_pkg::*;

  // The most significant nonzero lane sets the first printed digit.
  always_comb begin
    top_o = '0;
    for (int i = 0; i < WORD_DIGITS; i++) begin
      if (lanes_i[i].nonzero) begin
        top_o = DIG_W'(i);
      end
    end
  end
endmodule

[rtl/core/log_record_hex_formatter.sv]
// Log record hex formatter.
// Input channel in_i carries one record (event_id, event_param) per transfer.
// Output channel out_o carries one ASCII byte per transfer: the identifier in
// lower-case hex without leading zeros, a space, the parameter in the same
// form, CR and LF. last_byte marks the LF. A record gives 5 to 19 bytes.
// The first byte of a record passes through the line buffer and then the
// output register to out_o. Bytes then follow at one per cycle while the
// receiver does not stall; the single byte serializer sets this rate.
// The next record is taken in the same cycle that the LF of the previous one
// moves into the output register, so records stream without gaps.
// When the receiver stalls, the output register holds its byte and the
// serializer waits; the line buffer stays occupied and in_i.ready drops.
// Reset empties the line buffer and the output register; no other state is
// kept between records.
module log_record_hex_formatter #(
  parameter int unsigned WORD_DIGITS = lrhf_pkg::WORD_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lrhf_in_if.sink           in_i,
  lrhf_out_if.source        out_o
);
  import lrhf_pkg::*;

  localparam int unsigned DIG_W = (WORD_DIGITS > 1) ? $clog2(WORD_DIGITS) : 1;

  lane_res_t id_lanes  [WORD_DIGITS];
  lane_res_t par_lanes [WORD_DIGITS];
  logic [DIG_W-1:0] id_top;
  logic [DIG_W-1:0] par_top;

  for (genvar g = 0; g < WORD_DIGITS; g++) begin : g_lane
    logic [3:0] id_nib;
    logic [3:0] par_nib;
    if (g < WORD_NIBBLES) begin : g_word
      assign id_nib  = in_i.event_id[NIBBLE_BITS*g +: NIBBLE_BITS];
      assign par_nib = in_i.event_param[NIBBLE_BITS*g +: NIBBLE_BITS];
    end else begin : g_pad
      assign id_nib  = 4'h0;
      assign par_nib = 4'h0;
    end
    lrhf_lane u_id_lane  (.nib_i(id_nib),  .res_o(id_lanes[g]));
    lrhf_lane u_par_lane (.nib_i(par_nib), .res_o(par_lanes[g]));
  end

  lrhf_merge #(.WORD_DIGITS(WORD_DIGITS), .DIG_W(DIG_W)) u_id_merge (
    .lanes_i(id_lanes),
    .top_o  (id_top)
  );

  lrhf_merge #(.WORD_DIGITS(WORD_DIGITS), .DIG_W(DIG_W)) u_par_merge (
    .lanes_i(par_lanes),
    .top_o  (par_top)
  );

  logic             buf_valid_q, buf_valid_d;
  phase_e           phase_q, phase_d;
  logic [DIG_W-1:0] pos_q, pos_d;
  logic [7:0]       id_chars_q  [WORD_DIGITS];
  logic [7:0]       par_chars_q [WORD_DIGITS];
  logic [DIG_W-1:0] par_top_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic       adv;
  logic       in_xfer;
  logic [7:0] cur_char;

  assign adv        = buf_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !buf_valid_q || (adv && (phase_q == PH_LF));
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    case (phase_q)
      PH_ID:   cur_char = id_chars_q[pos_q];
      PH_SP:   cur_char = CH_SPACE;
      PH_PAR:  cur_char = par_chars_q[pos_q];
      PH_CR:   cur_char = CH_CR;
      PH_LF:   cur_char = CH_LF;
      default: cur_char = CH_LF;
    endcase
  end

  always_comb begin
    buf_valid_d = buf_valid_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    if (adv) begin
      case (phase_q)
        PH_ID: begin
          if (pos_q == '0) begin
            phase_d = PH_SP;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        PH_SP: begin
          phase_d = PH_PAR;
          pos_d   = par_top_q;
        end
        PH_PAR: begin
          if (pos_q == '0) begin
            phase_d = PH_CR;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        PH_CR:   phase_d = PH_LF;
        PH_LF:   buf_valid_d = 1'b0;
        default: buf_valid_d = 1'b0;
      endcase
    end
    if (in_xfer) begin
      buf_valid_d = 1'b1;
      phase_d     = PH_ID;
      pos_d       = id_top;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_char_d  = cur_char;
      out_last_d  = (phase_q == PH_LF);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      phase_q     <= PH_ID;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (in_xfer) begin
      par_top_q <= par_top;
      for (int i = 0; i < WORD_DIGITS; i++) begin
        id_chars_q[i]  <= id_lanes[i].char_byte;
        par_chars_q[i] <= par_lanes[i].char_byte;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_byte = out_char_q;
  assign out_o.last_byte = out_last_q;

  a_accept_starts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (buf_valid_q && (phase_q == PH_ID)))
    else $error("accepted record did not start a new line");

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_byte) |-> (out_o.char_byte == CH_LF))
    else $error("last byte of a record is not LF");

  a_space_after_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (phase_q == PH_SP)) |=> (out_valid_q && (out_char_q == CH_SPACE)
                                    && (phase_q == PH_PAR)))
    else $error("separator space not emitted before parameter");

  a_no_accept_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_valid_q && (phase_q != PH_LF)) |-> !in_i.ready)
    else $error("record accepted while a line is still being sent");
endmodule

[tb/log_record_hex_formatter_test.sv]
module log_record_hex_formatter_test;
  import lrhf_pkg::*;

  localparam int unsigned DIGITS = WORD_DIGITS_DEF;
  localparam int NDIR = 20;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lrhf_in_if  rec_if ();
  lrhf_out_if txt_if ();

  log_record_hex_formatter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rec_if),
    .out_o  (txt_if)
  );

  text_char_t pending_chars[$];
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_kick = 0;
  int records_sent = 0;
  int chars_checked = 0;
  int mismatches = 0;

  // An empty text means the row is checked against the predictor.
  logic [31:0] dir_id [NDIR] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'h0000_0010,
    32'h8000_0000, 32'h0000_0000, 32'h1234_5678, 32'hdead_beef, 32'h0000_000a,
    32'h00f0_0000, 32'h0f0f_0f0f, 32'h0000_0010, 32'h0100_0000, 32'h7fff_ffff,
    32'h5555_5555, 32'h0000_0100, 32'h0000_0003, 32'hc0de_0000, 32'h0000_ffff
  };
  logic [31:0] dir_param [NDIR] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
    32'h0000_0000, 32'h8000_0000, 32'h9abc_def0, 32'h0000_000f, 32'h0000_000b,
    32'h0000_0100, 32'hf0f0_f0f0, 32'h0000_0001, 32'h0000_0000, 32'h8000_0001,
    32'haaaa_aaaa, 32'h0001_0000, 32'hffff_fff0, 32'h0000_0007, 32'h000e_0000
  };
  string dir_text [NDIR] = '{
    "0 0", "ffffffff ffffffff", "1 0", "0 1", "10 0",
    "80000000 0", "0 80000000", "12345678 9abcdef0", "deadbeef f", "a b",
    "f00000 100", "f0f0f0f f0f0f0f0", "", "", "",
    "", "", "", "", ""
  };

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + nib : 8'h57 + nib;
  endfunction

  function automatic void push_char(input logic [7:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  function automatic void push_hex_word(input logic [31:0] word);
    logic [63:0] wide;
    logic [3:0] nib;
    bit started;
    wide = {32'h0, word};
    started = 1'b0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      nib = wide[i*4 +: 4];
      if (nib != 4'h0 || started || i == 0) begin
        started = 1'b1;
        push_char(hex_digit(nib), 1'b0);
      end
    end
  endfunction

  function automatic void format_record(input logic [31:0] id, input logic [31:0] param);
    push_hex_word(id);
    push_char(CH_SPACE, 1'b0);
    push_hex_word(param);
    push_char(CH_CR, 1'b0);
    push_char(CH_LF, 1'b1);
  endfunction

  function automatic void push_line(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], 1'b0);
    end
    push_char(CH_CR, 1'b0);
    push_char(CH_LF, 1'b1);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  // Called at a rising edge; returns at the rising edge of the transfer.
  task automatic send_record(input logic [31:0] id, input logic [31:0] param,
                             input string text);
    while ($urandom_range(99) < send_gap_pct) begin
      rec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rec_if.valid <= 1'b1;
    rec_if.event_id <= id;
    rec_if.event_param <= param;
    @(negedge clk_i);
    while (!rec_if.ready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    if (text.len() != 0) begin
      push_line(text);
    end else begin
      format_record(id, param);
    end
    records_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_record(random_word(), random_word(), "");
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever hold_kick moves.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    txt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        txt_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = LONG_HOLD;
        txt_if.ready <= 1'b0;
      end else begin
        txt_if.ready <= rst_ni && ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    text_char_t want;
    if (rst_ni && txt_if.valid && txt_if.ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected char %02h/%0b with nothing pending",
                   txt_if.char_byte, txt_if.last_byte);
        end
      end else begin
        want = pending_chars.pop_front();
        if (txt_if.char_byte !== want.code || txt_if.last_byte !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at char %0d: expected %02h/%0b, got %02h/%0b",
                     chars_checked, want.code, want.last,
                     txt_if.char_byte, txt_if.last_byte);
          end
        end
      end
      chars_checked++;
    end
  end

  initial begin
    rec_if.valid <= 1'b0;
    rec_if.event_id <= 32'h0;
    rec_if.event_param <= 32'h0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 10;
    recv_gap_pct = 62;
    for (int k = 0; k < NDIR; k++) begin
      send_record(dir_id[k], dir_param[k], dir_text[k]);
    end
    send_random(100);

    // The sender waits here until every character has come out.
    rec_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);

    // Back-to-back records against a long receiver hold-off fill the block.
    send_gap_pct = 0;
    hold_kick <= hold_kick + 1;
    send_random(12);

    send_gap_pct = 62;
    recv_gap_pct = 10;
    send_random(100);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    send_random(100);

    rec_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d records sent (%0d directed), %0d characters checked, %0d mismatches",
             records_sent, NDIR, chars_checked, mismatches);
    $display("Covered idle sender, idle receiver, no idling and a long output stall.");
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("log_record_hex_formatter regression: pass");
    end else begin
      $display("log_record_hex_formatter regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("log_record_hex_formatter regression: fail");
    $finish;
  end

endmodule

[log_record_hex_formatter.f]
rtl/core/lrhf_pkg.sv
rtl/core/lrhf_in_if.sv
rtl/core/lrhf_out_if.sv
rtl/core/lrhf_lane.sv
rtl/core/lrhf_merge.sv
rtl/core/log_record_hex_formatter.sv
tb/log_record_hex_formatter_test.sv
